### rtl/descriptor_table_alloc_search_defines.svh
// ----------------------------------------------------------------------------
// descriptor table assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_TABLE_ALLOC_SEARCH_DEFINES_SVH
`define DESCRIPTOR_TABLE_ALLOC_SEARCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dtas assertion failed");

// next-cycle implication, disabled during reset
`define DTAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dtas assertion failed");

`endif

### rtl/dtas_pkg.sv
// ----------------------------------------------------------------------------
// dtas_pkg
// constants, codes and the probe word that walks the descriptor cell chain
// ----------------------------------------------------------------------------
package dtas_pkg;

  // number of descriptor cells in the chain (2 to 256)
  localparam int unsigned TABLE_DEPTH = 64;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned KIND_W  = 32;
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_DEL        = 3'd1,
    OP_FIND_KIND  = 3'd2,
    OP_FIND_OWNER = 3'd3,
    OP_FIND_BOTH  = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVAL    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // request in flight, handed from cell to cell each cycle while the chain is not held
  typedef struct packed {
    logic                active;
    logic                done;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    idx;
    logic [KIND_W-1:0]   kind;
    logic [OWNER_W-1:0]  owner;
    logic [IDX_W-1:0]    pos;
    status_e             status;
    logic [IDX_W-1:0]    index;
  } probe_t;

endpackage

### rtl/dtas_req_if.sv
// ----------------------------------------------------------------------------
// dtas_req_if
// request channel: opcode, slot index, resource kind and owner id
// ----------------------------------------------------------------------------
interface dtas_req_if import dtas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [IDX_W-1:0]   slot_index;
  logic [KIND_W-1:0]  res_kind;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, opcode, slot_index, res_kind, owner_id, input ready);
  modport sink   (input valid, opcode, slot_index, res_kind, owner_id, output ready);
endinterface

### rtl/dtas_rsp_if.sv
// ----------------------------------------------------------------------------
// dtas_rsp_if
// response channel: status and allocated or found slot index
// ----------------------------------------------------------------------------
interface dtas_rsp_if import dtas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  found_index;

  modport source (output valid, status, found_index, input ready);
  modport sink   (input valid, status, found_index, output ready);
endinterface

### rtl/descriptor_table_alloc_search.sv
// ----------------------------------------------------------------------------
// descriptor_table_alloc_search
// descriptor table with first-free allocation, delete and upward finds
// ----------------------------------------------------------------------------
// Requests arrive on req_i (opcode, slot_index, res_kind, owner_id) and each
// gives exactly one word on rsp_o (status, found_index), in request order.
// The table is a chain of TABLE_DEPTH cells, one per slot. An accepted
// request becomes a probe that enters cell 0 and moves one cell per cycle
// while the chain is not held; the first cell that can serve it (lowest
// free slot for add, the named slot for delete, the first matching valid
// slot at or above the start index for a find) acts and marks the probe
// done. At the chain end the probe turns into a response word in the
// output register, after passing the register of every cell in the chain.
// One request is in the chain at a time; a new request is taken as soon
// as the previous one has reached the output register, even while that
// response still waits.
// If the receiver stalls and a second response reaches the chain end, the
// whole chain holds until the output register frees.
// Reset clears all valid marks at once; kind and owner are not reset.
// ----------------------------------------------------------------------------
module descriptor_table_alloc_search import dtas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtas_req_if.sink   req_i,
  dtas_rsp_if.source rsp_o
);

  probe_t chain [TABLE_DEPTH+1];
  probe_t launch, last;

  logic              busy_q;
  logic              rsp_valid_q;
  status_e           rsp_status_q;
  logic [IDX_W-1:0]  rsp_index_q;
  logic              accept, adv, unload, known_op;
  status_e           final_status;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = !busy_q;

  // launch probe; unknown opcodes leave already answered
  always_comb begin
    known_op = (req_i.opcode == OP_ADD) || (req_i.opcode == OP_DEL) ||
               (req_i.opcode == OP_FIND_KIND) || (req_i.opcode == OP_FIND_OWNER) ||
               (req_i.opcode == OP_FIND_BOTH);
    launch        = '0;
    launch.active = accept;
    launch.done   = !known_op;
    launch.op     = req_i.opcode;
    launch.idx    = req_i.slot_index;
    launch.kind   = req_i.res_kind;
    launch.owner  = req_i.owner_id;
    launch.status = ST_INVAL;
  end

  assign chain[0] = launch;

  // row of descriptor cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dtas_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .probe_i (chain[g]),
      .probe_o (chain[g+1])
    );
  end

  assign last   = chain[TABLE_DEPTH];
  assign unload = last.active && (!rsp_valid_q || rsp_o.ready);
  assign adv    = !(last.active && rsp_valid_q && !rsp_o.ready);

  // final status: the answer the probe carries, or the status of a probe that no cell answered
  always_comb begin
    if (last.done) begin
      final_status = last.status;
    end else if (last.op == OP_ADD) begin
      final_status = ST_FULL;
    end else if (last.op == OP_DEL) begin
      final_status = ST_INVAL;
    end else begin
      final_status = ST_NOTFOUND;
    end
  end

  // busy flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (unload) begin
        busy_q <= 1'b0;
      end
      if (unload) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (unload) begin
      rsp_status_q <= final_status;
      rsp_index_q  <= (last.done && (last.status == ST_OK)) ? last.index : '0;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_index = rsp_index_q;

endmodule

### rtl/dtas_cell.sv
// ----------------------------------------------------------------------------
// dtas_cell
// one descriptor slot: holds valid, kind and owner, acts on the passing probe
// ----------------------------------------------------------------------------
module dtas_cell import dtas_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  probe_t probe_i,
  output probe_t probe_o
);

  logic                valid_q, valid_d;
  logic [KIND_W-1:0]   kind_q;
  logic [OWNER_W-1:0]  owner_q;
  probe_t              probe_q, probe_d;

  logic take, is_find, match_kind, match_owner;
  logic hit_add, hit_del, hit_find;

  // decide whether this slot answers the probe
  always_comb begin
    take        = probe_i.active && !probe_i.done;
    is_find     = (probe_i.op == OP_FIND_KIND) || (probe_i.op == OP_FIND_OWNER) ||
                  (probe_i.op == OP_FIND_BOTH);
    match_kind  = (probe_i.op == OP_FIND_OWNER) || (kind_q == probe_i.kind);
    match_owner = (probe_i.op == OP_FIND_KIND) || (owner_q == probe_i.owner);
    hit_add     = (probe_i.op == OP_ADD) && !valid_q;
    hit_del     = (probe_i.op == OP_DEL) && (probe_i.pos == probe_i.idx);
    hit_find    = is_find && valid_q && (probe_i.pos >= probe_i.idx) &&
                  match_kind && match_owner;
  end

  // next probe word and slot valid mark
  always_comb begin
    probe_d     = probe_i;
    probe_d.pos = probe_i.pos + IDX_W'(1);
    valid_d     = valid_q;
    if (take && (hit_add || hit_del || hit_find)) begin
      probe_d.done   = 1'b1;
      probe_d.status = ST_OK;
      probe_d.index  = hit_del ? '0 : probe_i.pos;
    end
    if (take && hit_add) begin
      valid_d = 1'b1;
    end else if (take && hit_del) begin
      valid_d = 1'b0;
    end
  end

  // slot valid mark and probe register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      probe_q <= probe_d;
    end
  end

  // slot contents
  always_ff @(posedge clk_i) begin
    if (adv_i && take && hit_add) begin
      kind_q  <= probe_i.kind;
      owner_q <= probe_i.owner;
    end
  end

  assign probe_o = probe_q;

endmodule

### rtl/dtas_checker.sv
// ----------------------------------------------------------------------------
// dtas_checker
// port-level assertions for the descriptor table, bound to the top level
// ----------------------------------------------------------------------------
`include "descriptor_table_alloc_search_defines.svh"

module dtas_checker import dtas_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [STAT_W-1:0]  rsp_status_i,
  input logic [IDX_W-1:0]   rsp_index_i
);

  // a stalled response word holds its status
  `DTAS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i))

  // one request in the chain at a time
  `DTAS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // a failed request carries index zero
  `DTAS_ASSERT_NOW(a_fail_index_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != ST_OK), rsp_index_i == '0)

  // a returned slot lies inside the table
  `DTAS_ASSERT_NOW(a_index_range, clk_i, rst_ni, rsp_valid_i, 32'(rsp_index_i) < TABLE_DEPTH)

endmodule

bind descriptor_table_alloc_search dtas_checker u_dtas_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_index_i  (rsp_o.found_index)
);

### sim/descriptor_table_alloc_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descriptor_table_alloc_search_test
// self-checking bench for the descriptor table: add, delete and the finds
// ----------------------------------------------------------------------------
// A queue of request words feeds a clocked driver, and a clocked monitor
// checks every response word against a shadow copy of the table that is
// updated at each accepted request. Directed words cover the extremes and
// the corner cases first, then random phases fill the table to full, churn
// it, drain it and refill it. Both channels stall at random outside a quiet
// window.
// ----------------------------------------------------------------------------
module descriptor_table_alloc_search_test;
  import dtas_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned QUIET_FIRST = 6000;
  localparam int unsigned QUIET_LAST  = 12000;
  localparam int unsigned IDLE_PCT    = 15;

  // opcodes outside the defined set
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   slot_index;
    logic [KIND_W-1:0]  res_kind;
    logic [OWNER_W-1:0] owner_id;
  } request_t;

  typedef struct {
    status_e          status;
    logic [IDX_W-1:0] index;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  dtas_req_if req_if ();
  dtas_rsp_if rsp_if ();

  descriptor_table_alloc_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow table
  bit                 slot_used  [TABLE_DEPTH];
  logic [KIND_W-1:0]  slot_kind_m  [TABLE_DEPTH];
  logic [OWNER_W-1:0] slot_owner_m [TABLE_DEPTH];

  request_t    send_q[$];
  reply_t      expected_replies[$];
  request_t    cur_req;
  bit          req_taken;
  bit          progress;
  int unsigned cycle_cnt;
  int unsigned stall_cycles;
  int unsigned n_queued;
  int unsigned n_checked;
  int unsigned n_errors;

  // apply one request to the shadow table and return the expected word
  function automatic reply_t table_apply(input request_t r);
    reply_t      rep;
    int unsigned k;
    bit          hit;
    rep.status = ST_OK;
    rep.index  = '0;
    hit        = 1'b0;
    case (r.opcode) inside
      OP_ADD: begin
        for (k = 0; k < TABLE_DEPTH; k++) begin
          if (!hit && !slot_used[k]) begin
            hit             = 1'b1;
            slot_used[k]    = 1'b1;
            slot_kind_m[k]  = r.res_kind;
            slot_owner_m[k] = r.owner_id;
            rep.index       = k[IDX_W-1:0];
          end
        end
        if (!hit) rep.status = ST_FULL;
      end
      OP_DEL: begin
        if (r.slot_index >= TABLE_DEPTH) rep.status = ST_INVAL;
        else slot_used[r.slot_index] = 1'b0;
      end
      OP_FIND_KIND, OP_FIND_OWNER, OP_FIND_BOTH: begin
        for (k = r.slot_index; k < TABLE_DEPTH; k++) begin
          if (!hit && slot_used[k] &&
              (r.opcode == OP_FIND_OWNER || slot_kind_m[k] == r.res_kind) &&
              (r.opcode == OP_FIND_KIND || slot_owner_m[k] == r.owner_id)) begin
            hit       = 1'b1;
            rep.index = k[IDX_W-1:0];
          end
        end
        if (!hit) rep.status = ST_NOTFOUND;
      end
      default: rep.status = ST_INVAL;
    endcase
    return rep;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 4) == 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1234_5678;
      default: return 32'h8000_0001;
    endcase
  endfunction

  function automatic logic [OWNER_W-1:0] pick_owner();
    if ($urandom_range(0, 4) == 0) return OWNER_W'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00A5;
      default: return 16'h8001;
    endcase
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [KIND_W-1:0] kind,
                           input logic [OWNER_W-1:0] owner);
    request_t r;
    r.opcode     = op;
    r.slot_index = idx;
    r.res_kind   = kind;
    r.owner_id   = owner;
    send_q.push_back(r);
    n_queued++;
  endtask

  // one random word; the percentages steer the table toward full or empty
  task automatic queue_random(input int unsigned add_pct, input int unsigned del_pct);
    int unsigned roll;
    logic [IDX_W-1:0] start;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      queue_req(OP_ADD, IDX_W'($urandom_range(0, 255)), pick_kind(), pick_owner());
    end else if (roll < add_pct + del_pct) begin
      if ($urandom_range(0, 9) == 0) start = IDX_W'($urandom_range(0, 255));
      else start = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      queue_req(OP_DEL, start, $urandom, OWNER_W'($urandom_range(0, 16'hFFFF)));
    end else if (roll < 97) begin
      case ($urandom_range(0, 5))
        0, 1:    start = '0;
        2:       start = IDX_W'($urandom_range(0, 255));
        default: start = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      endcase
      case ($urandom_range(0, 2))
        0:       queue_req(OP_FIND_KIND, start, pick_kind(), pick_owner());
        1:       queue_req(OP_FIND_OWNER, start, pick_kind(), pick_owner());
        default: queue_req(OP_FIND_BOTH, start, pick_kind(), pick_owner());
      endcase
    end else begin
      queue_req(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                IDX_W'($urandom_range(0, 255)),
                $urandom, OWNER_W'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (n_checked != n_queued) @(negedge clk_i);
  endtask

  // clock and known input levels from time zero
  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = '0;
    req_if.slot_index = '0;
    req_if.res_kind   = '0;
    req_if.owner_id   = '0;
    rsp_if.ready      = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request driver and response ready, both at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (cycle_cnt >= QUIET_FIRST && cycle_cnt < QUIET_LAST) ||
                      ($urandom_range(0, 99) >= IDLE_PCT);
      if (!req_if.valid || req_taken) begin
        req_taken = 1'b0;
        if (send_q.size() != 0 &&
            ((cycle_cnt >= QUIET_FIRST && cycle_cnt < QUIET_LAST) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = send_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.opcode     <= cur_req.opcode;
          req_if.slot_index <= cur_req.slot_index;
          req_if.res_kind   <= cur_req.res_kind;
          req_if.owner_id   <= cur_req.owner_id;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on request accept, check on response accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      progress = 1'b0;
      if (req_if.valid && req_if.ready) begin
        expected_replies.push_back(table_apply(cur_req));
        req_taken = 1'b1;
        progress  = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        progress = 1'b1;
        n_checked++;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected word status %0d index %0d", $time,
                   rsp_if.status, rsp_if.found_index);
          n_errors++;
        end else begin
          reply_t exp_rep;
          exp_rep = expected_replies.pop_front();
          if (rsp_if.status !== exp_rep.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rep.status, rsp_if.status);
            n_errors++;
          end
          if (rsp_if.found_index !== exp_rep.index) begin
            $display("%0t: found_index expected %0d actual %0d", $time,
                     exp_rep.index, rsp_if.found_index);
            n_errors++;
          end
        end
      end
      // watchdog on cycles without any handshake
      if (progress) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
        $display("FAIL descriptor_table_alloc_search");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    req_taken    = 1'b0;
    cycle_cnt    = 0;
    stall_cycles = 0;
    n_queued     = 0;
    n_checked    = 0;
    n_errors     = 0;
    foreach (slot_used[k]) slot_used[k] = 1'b0;

    // delete out of range, delete of a free slot, find in an empty table
    queue_req(OP_DEL, IDX_W'(TABLE_DEPTH), 32'h0, 16'h0);
    queue_req(OP_DEL, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
    queue_req(OP_DEL, 8'd0, 32'h0, 16'h0);
    queue_req(OP_FIND_KIND, 8'd0, 32'h0, 16'h0);
    // first adds take the lowest slots
    queue_req(OP_ADD, 8'd0, 32'h0000_0000, 16'h0000);
    queue_req(OP_ADD, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
    queue_req(OP_ADD, 8'd0, 32'h0000_0000, 16'hFFFF);
    // finds: hits, skipped start, no match and start at or past the end
    queue_req(OP_FIND_KIND, 8'd0, 32'h0000_0000, 16'h1234);
    queue_req(OP_FIND_KIND, 8'd1, 32'h0000_0000, 16'h0000);
    queue_req(OP_FIND_OWNER, 8'd0, 32'h5A5A_5A5A, 16'hFFFF);
    queue_req(OP_FIND_BOTH, 8'd0, 32'h0000_0000, 16'hFFFF);
    queue_req(OP_FIND_BOTH, 8'd0, 32'hFFFF_FFFF, 16'h0000);
    queue_req(OP_FIND_OWNER, IDX_W'(TABLE_DEPTH - 1), 32'h0, 16'hFFFF);
    queue_req(OP_FIND_KIND, IDX_W'(TABLE_DEPTH), 32'h0, 16'h0);
    queue_req(OP_FIND_OWNER, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
    // delete twice, then the freed slot is reused
    queue_req(OP_DEL, 8'd1, 32'h0, 16'h0);
    queue_req(OP_DEL, 8'd1, 32'h0, 16'h0);
    queue_req(OP_ADD, 8'd0, 32'hA5A5_A5A5, 16'h5A5A);
    queue_req(OP_DEL, IDX_W'(TABLE_DEPTH - 1), 32'h0, 16'h0);
    // unknown opcodes
    queue_req(OP_UNUSED_LO, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
    queue_req(OP_UNUSED_LO + 3'd1, 8'd0, 32'h0, 16'h0);
    queue_req(OP_UNUSED_HI, 8'd3, 32'h0, 16'hFFFF);
    queue_req(OP_FIND_KIND, 8'd0, 32'hA5A5_A5A5, 16'h0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // hold the sender until every directed word is back
    wait_drained();
    @(posedge clk_i);

    // fill to full, churn, drain, refill
    repeat (130) queue_random(85, 5);
    repeat (100) queue_random(40, 30);
    repeat (100) queue_random(10, 55);
    repeat (120) queue_random(80, 10);

    wait_drained();
    repeat (TABLE_DEPTH + 8) @(negedge clk_i);
    if (expected_replies.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, expected_replies.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("PASS descriptor_table_alloc_search");
    end else begin
      $display("FAIL descriptor_table_alloc_search");
    end
    $finish;
  end

endmodule
